FILE: hw/rtl/terminal_output_escape_processor_assert.svh
// assertion macros for the terminal output escape processor
// expects clk and arst_n in the scope of use
`ifndef TERMINAL_OUTPUT_ESCAPE_PROCESSOR_ASSERT_SVH
`define TERMINAL_OUTPUT_ESCAPE_PROCESSOR_ASSERT_SVH

// condition holds in the same cycle
`define TOEP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("toep assertion failed");

// condition holds in the next cycle
`define TOEP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("toep assertion failed");

`endif

FILE: hw/rtl/toep_pkg.sv
// shared types and constants of the terminal output escape processor
// no dependencies
`default_nettype none

package toep_pkg;

	localparam int MAX_ARGS_DEF = 16;
	localparam int TAB_STOP_DEF = 8;
	localparam int QUEUE_DEPTH  = 4;
	localparam int RUN_LIMIT    = 16;

	localparam int COL_W       = 9;
	localparam int ENTRY_PH_W  = 4;
	localparam int ENTRY_CNT_W = 6;
	localparam int APB_ADDR_W  = 5;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HIDDEN = 8'hFF;
	localparam logic [31:0] DEC_BASE = 32'd10;

	localparam logic [2:0] REG_PROC_ON  = 3'd0;
	localparam logic [2:0] REG_RAW      = 3'd1;
	localparam logic [2:0] REG_CRLF     = 3'd2;
	localparam logic [2:0] REG_CR2LF    = 3'd3;
	localparam logic [2:0] REG_COLUMNS  = 3'd4;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_CRLF = 2'd1,
		OP_TAB  = 2'd2,
		OP_CMD  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [7:0]             data;
		logic [COL_W-1:0]       col;
		logic [ENTRY_PH_W-1:0]  ph;
		logic [ENTRY_CNT_W-1:0] cnt;
	} q_entry_t;

	typedef struct packed {
		logic       proc_on;
		logic       raw;
		logic       crlf;
		logic       cr2lf;
		logic [7:0] columns;
	} cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/terminal_output_escape_processor.sv
// Terminal output escape processor. Each accepted byte but 0xFF is shown as-is
// (raw mode, or processing off) or run through newline mapping, tab expansion
// and an ESC [ args letter parser, giving display bytes and command elements.
// Results leave the back part's output register one per cycle while out_stall
// is low, so a plain byte gives one result, newline with CR two, a tab up to
// TAB_STOP spaces, and a command one element per argument (at most 16). A
// four-entry queue lets bytes keep coming while that happens; inside an argument
// the input stalls until any earlier command has fully left, since both share
// the argument store. Configuration lives at byte addresses 0, 4, 8, 12 and 16.
// top level; depends on toep_pkg, toep_front, toep_queue, toep_back and the
// assertion macro header
`default_nettype none

`include "terminal_output_escape_processor_assert.svh"

module terminal_output_escape_processor import toep_pkg::*; #(
	parameter int MAX_ARGS = MAX_ARGS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF,
	parameter int QDEPTH   = QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic [7:0]            cursor_column,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       item_kind,
	output logic [7:0]                 out_byte,
	output logic [4:0]                 arg_total,
	output logic [3:0]                 arg_index,
	output logic [31:0]                arg_value,
	output logic                       last
);

	localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	cfg_t             cfg_q;
	logic [2:0]       reg_idx;
	logic             wr_en;
	logic             push;
	q_entry_t         push_entry;
	logic             full;
	logic             pop;
	logic             head_valid;
	q_entry_t         head;
	logic             cmd_done;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0]      rd_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{proc_on: 1'b1, raw: 1'b0, crlf: 1'b1, cr2lf: 1'b0, columns: 8'd80};
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PROC_ON: cfg_q.proc_on <= pwdata[0];
				REG_RAW:     cfg_q.raw     <= pwdata[0];
				REG_CRLF:    cfg_q.crlf    <= pwdata[0];
				REG_CR2LF:   cfg_q.cr2lf   <= pwdata[0];
				REG_COLUMNS: cfg_q.columns <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PROC_ON: prdata = {31'd0, cfg_q.proc_on};
			REG_RAW:     prdata = {31'd0, cfg_q.raw};
			REG_CRLF:    prdata = {31'd0, cfg_q.crlf};
			REG_CR2LF:   prdata = {31'd0, cfg_q.cr2lf};
			REG_COLUMNS: prdata = {24'd0, cfg_q.columns};
			default:     prdata = '0;
		endcase
	end

	toep_front #(
		.MAX_ARGS (MAX_ARGS),
		.TAB_STOP (TAB_STOP),
		.QDEPTH   (QDEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.cursor_column (cursor_column),
		.push          (push),
		.push_entry    (push_entry),
		.full          (full),
		.cmd_done      (cmd_done),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	toep_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	toep_back #(
		.MAX_ARGS (MAX_ARGS),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.screen_columns (cfg_q.columns),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.cmd_done       (cmd_done),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.out_byte       (out_byte),
		.arg_total      (arg_total),
		.arg_index      (arg_index),
		.arg_value      (arg_value),
		.last           (last)
	);

	`TOEP_ASSERT_NOW(a_hidden_never_shown, out_valid && !item_kind, out_byte != CH_HIDDEN)
	`TOEP_ASSERT_NOW(a_display_no_args, out_valid && !item_kind,
		arg_total == 5'd0 && arg_index == 4'd0 && arg_value == 32'd0)
	`TOEP_ASSERT_NOW(a_index_in_range, out_valid && item_kind && arg_total != 5'd0,
		{1'b0, arg_index} < arg_total)
	`TOEP_ASSERT_NOW(a_full_blocks_input, full, !push)
	`TOEP_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall,
		out_valid && $stable(out_byte) && $stable(arg_value) && $stable(last))

endmodule

`default_nettype wire

FILE: hw/rtl/toep_queue.sv
// short work queue between the front and back parts
// depends on toep_pkg
`default_nettype none

module toep_queue import toep_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_entry,
	output logic          full,
	input  wire logic     pop,
	output logic          head_valid,
	output q_entry_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/toep_front.sv
// front part: accepts bytes, runs the escape parser and classifies work
// holds the argument store; depends on toep_pkg
`default_nettype none

module toep_front import toep_pkg::*; #(
	parameter int MAX_ARGS = MAX_ARGS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF,
	parameter int QDEPTH   = QUEUE_DEPTH,
	localparam int IDX_W   = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic [7:0]       cursor_column,
	output logic                  push,
	output q_entry_t              push_entry,
	input  wire logic             full,
	input  wire logic             cmd_done,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic [31:0]           rd_data
);

	localparam int CNT_W  = $clog2(MAX_ARGS + 1);
	localparam int PEND_W = $clog2(QDEPTH + 1);
	localparam int RECIP  = (1 << 16) / TAB_STOP + 1;

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_ESC  = 2'd1;
	localparam logic [1:0] PH_OPEN = 2'd2;
	localparam logic [1:0] PH_ARG  = 2'd3;

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_AT);
	endfunction

	logic [1:0]        phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [31:0]       acc_q, acc_d;
	logic [PEND_W-1:0] pend_q;
	logic [31:0]       store_q [MAX_ARGS];

	logic              processed;
	logic              accept;
	logic              push_c;
	logic              st_we;
	logic              ordinary;
	logic              digit;
	logic              letter;
	logic              cnt_room;
	logic [7:0]        dsub;
	logic [3:0]        dval;
	logic [COL_W-1:0]  col0;
	logic [25:0]       prod;
	logic [COL_W-1:0]  quot;
	logic [COL_W-1:0]  rem;

	assign processed = cfg.proc_on && !cfg.raw;
	assign in_stall  = full || (processed && (phase_q == PH_ARG) && (pend_q != '0));
	assign accept    = in_valid && !in_stall;
	assign push      = push_c && accept;
	assign rd_data   = store_q[rd_addr];

	assign digit    = is_digit(data_byte);
	assign letter   = is_letter(data_byte);
	assign dsub     = data_byte - CH_ZERO;
	assign dval     = dsub[3:0];
	assign cnt_room = (cnt_q < CNT_W'(MAX_ARGS));

	// column after the first space, and its place within the tab stop
	assign col0 = {1'b0, cursor_column} + 9'd1;
	assign prod = {17'd0, col0} * 26'(RECIP);
	assign quot = prod[24:16];
	assign rem  = col0 - COL_W'(quot * COL_W'(TAB_STOP));

	always_comb begin
		push_c     = 1'b0;
		push_entry = '{op: OP_BYTE, data: data_byte, col: col0,
			ph: rem[ENTRY_PH_W-1:0], cnt: '0};
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		acc_d      = acc_q;
		st_we      = 1'b0;
		ordinary   = 1'b0;
		if (!processed) begin
			push_c = (data_byte != CH_HIDDEN);
		end else begin
			unique case (phase_q)
				PH_WAIT: begin
					if (data_byte == CH_ESC) begin
						phase_d = PH_ESC;
					end else begin
						ordinary = 1'b1;
					end
				end
				PH_ESC: begin
					if (data_byte == CH_LBRACK) begin
						phase_d = PH_OPEN;
					end else if (data_byte != CH_ESC) begin
						phase_d  = PH_WAIT;
						ordinary = 1'b1;
					end
				end
				PH_OPEN: begin
					cnt_d = '0;
					if (digit) begin
						acc_d   = {28'd0, dval};
						phase_d = PH_ARG;
					end else if (letter) begin
						push_c        = 1'b1;
						push_entry.op = OP_CMD;
						phase_d       = PH_WAIT;
					end
				end
				default: begin
					if (digit) begin
						acc_d = acc_q * DEC_BASE + {28'd0, dval};
					end else if (data_byte == CH_SEMI) begin
						acc_d = '0;
						if (cnt_room) begin
							st_we = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end
					end else begin
						if (cnt_room) begin
							st_we = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end
						if (letter) begin
							push_c         = 1'b1;
							push_entry.op  = OP_CMD;
							push_entry.cnt = ENTRY_CNT_W'(cnt_d);
						end
						phase_d = PH_WAIT;
					end
				end
			endcase
			if (ordinary) begin
				priority if (data_byte == CH_LF && cfg.crlf) begin
					push_c        = 1'b1;
					push_entry.op = OP_CRLF;
				end else if (data_byte == CH_CR && cfg.cr2lf) begin
					push_c          = 1'b1;
					push_entry.data = CH_LF;
				end else if (data_byte == CH_TAB) begin
					push_c        = 1'b1;
					push_entry.op = OP_TAB;
				end else begin
					push_c = (data_byte != CH_HIDDEN);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && st_we) begin
			store_q[cnt_q[IDX_W-1:0]] <= acc_q;
		end
		if (accept) begin
			acc_q <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cnt_q   <= '0;
			pend_q  <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
			end
			if ((push && push_entry.op == OP_CMD) && !cmd_done) begin
				pend_q <= pend_q + 1'b1;
			end else if (!(push && push_entry.op == OP_CMD) && cmd_done) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/toep_back.sv
// back part: expands queued work to items, one per unstalled cycle
// reads the argument store of the front part; depends on toep_pkg
`default_nettype none

module toep_back import toep_pkg::*; #(
	parameter int MAX_ARGS = MAX_ARGS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF,
	localparam int IDX_W   = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       screen_columns,
	input  wire logic             head_valid,
	input  wire q_entry_t         head,
	output logic                  pop,
	output logic                  cmd_done,
	output logic [IDX_W-1:0]      rd_addr,
	input  wire logic [31:0]      rd_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  item_kind,
	output logic [7:0]            out_byte,
	output logic [4:0]            arg_total,
	output logic [3:0]            arg_index,
	output logic [31:0]           arg_value,
	output logic                  last
);

	localparam int ELEM_MAX = (MAX_ARGS < RUN_LIMIT) ? MAX_ARGS : RUN_LIMIT;

	logic [4:0]             sub_q;
	logic [COL_W-1:0]       col_q, col_d;
	logic [ENTRY_PH_W-1:0]  ph_q, ph_d;
	logic                   out_valid_q;

	logic                   load;
	logic                   wrap;
	logic [ENTRY_CNT_W-1:0] elems;
	logic                   r_kind;
	logic [7:0]             r_byte;
	logic [4:0]             r_total;
	logic [3:0]             r_index;
	logic [31:0]            r_value;
	logic                   r_last;

	assign rd_addr   = sub_q[IDX_W-1:0];
	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && r_last;
	assign cmd_done  = pop && (head.op == OP_CMD);
	assign out_valid = out_valid_q;

	assign wrap  = ({1'b0, col_q} + 10'd1) >= {2'b0, screen_columns};
	assign elems = (head.cnt == '0) ? ENTRY_CNT_W'(1) :
		((head.cnt > ENTRY_CNT_W'(ELEM_MAX)) ? ENTRY_CNT_W'(ELEM_MAX) : head.cnt);

	always_comb begin
		r_kind  = 1'b0;
		r_byte  = head.data;
		r_total = '0;
		r_index = '0;
		r_value = '0;
		r_last  = 1'b1;
		col_d   = col_q;
		ph_d    = ph_q;
		unique case (head.op)
			OP_BYTE: begin
				r_last = 1'b1;
			end
			OP_CRLF: begin
				r_byte = (sub_q == '0) ? CH_CR : CH_LF;
				r_last = (sub_q != '0);
			end
			OP_TAB: begin
				r_byte = CH_SPACE;
				if (sub_q == '0) begin
					col_d  = head.col;
					ph_d   = head.ph;
					r_last = (head.ph == '0);
				end else begin
					col_d  = wrap ? '0 : col_q + 1'b1;
					ph_d   = (wrap || ph_q == ENTRY_PH_W'(TAB_STOP - 1)) ? '0 : ph_q + 1'b1;
					r_last = (ph_d == '0);
				end
			end
			default: begin
				r_kind  = 1'b1;
				r_total = head.cnt[4:0];
				r_index = sub_q[3:0];
				r_value = (head.cnt == '0) ? '0 : rd_data;
				r_last  = ({1'b0, sub_q} + 6'd1) == elems;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_q     <= col_d;
			ph_q      <= ph_d;
			item_kind <= r_kind;
			out_byte  <= r_byte;
			arg_total <= r_total;
			arg_index <= r_index;
			arg_value <= r_value;
			last      <= r_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				sub_q       <= r_last ? '0 : sub_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
